/* rtl/core/scre_pkg.sv */
`timescale 1ns / 1ps

package scre_pkg;

  // Default sizes
  localparam int QUEUE_SLOTS_DEF  = 4;
  localparam int CONFIG_BYTES_DEF = 128;

  // Job lengths and stepper tick count
  localparam int REALTIME_LEN    = 22;
  localparam int SHORT_STORE_LEN = 'h7c;
  localparam logic [3:0] STEP_TICK_COUNT = 4'd10;

  // Command bytes
  localparam logic [7:0] CMD_REALTIME = 8'h41;  // 'A'
  localparam logic [7:0] CMD_SAVE     = 8'h42;  // 'B'
  localparam logic [7:0] CMD_SECONDS  = 8'h43;  // 'C'
  localparam logic [7:0] CMD_FLUSH    = 8'h46;  // 'F'
  localparam logic [7:0] CMD_VERSION  = 8'h51;  // 'Q'
  localparam logic [7:0] CMD_CLOSE    = 8'h53;  // 'S'
  localparam logic [7:0] CMD_STORE    = 8'h54;  // 'T'
  localparam logic [7:0] CMD_SHORT    = 8'h56;  // 'V'
  localparam logic [7:0] CMD_WRITE    = 8'h57;  // 'W'
  localparam logic [7:0] CMD_OPEN     = 8'h73;  // 's'

  // Register indexes
  localparam logic [0:0] REG_FIRMWARE_VERSION = 1'b0;

  typedef enum logic [1:0] {
    PH_CMD    = 2'd0,
    PH_OFFSET = 2'd1,
    PH_VALUE  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    EV_TX_BYTE      = 3'd0,
    EV_CONFIG_WRITE = 3'd1,
    EV_SAVE         = 3'd2,
    EV_STEP_OPEN    = 3'd3,
    EV_STEP_CLOSE   = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    SRC_STORE    = 2'd0,
    SRC_REALTIME = 2'd1,
    SRC_VERSION  = 2'd2,
    SRC_SECONDS  = 2'd3
  } source_t;

  typedef struct packed {
    source_t    source;
    logic [7:0] last;
    logic [7:0] count;
  } job_t;

endpackage

/* rtl/core/serial_command_response_engine.sv */
`timescale 1ns / 1ps

// Each result is registered: it appears on the output register in the cycle after its transaction is accepted.
// Throughput: one input transaction per cycle; the output register lets a new transaction in
// whenever the held result is taken in the same cycle or none is held.
// Reset (rst, synchronous): command phase, empty queue, version zero, and every store
// valid bit cleared so that unwritten store bytes read as zero.
module serial_command_response_engine
  import scre_pkg::*;
#(
  parameter int QUEUE_SLOTS  = QUEUE_SLOTS_DEF,
  parameter int CONFIG_BYTES = CONFIG_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  rx_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_kind,
  output logic [1:0]  tx_source,
  output logic [7:0]  byte_index,
  output logic [7:0]  byte_value,
  output logic [3:0]  step_ticks,
  output logic        tx_pending,
  output logic        job_dropped,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int QW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int AW = $clog2(CONFIG_BYTES);
  localparam logic [8:0] STORE_SIZE = 9'(CONFIG_BYTES);
  localparam logic [QW-1:0] PTR_LAST = QW'(QUEUE_SLOTS - 1);
  localparam logic [7:0] LAST_REALTIME = 8'(REALTIME_LEN - 1);
  localparam logic [7:0] LAST_SHORT    = 8'(SHORT_STORE_LEN - 1);
  localparam logic [7:0] LAST_STORE    = 8'(CONFIG_BYTES - 1);
  localparam logic [7:0] LAST_SINGLE   = 8'd0;

  // Control state
  phase_t          phase, phase_next;
  logic [7:0]      pending_offset, offset_next;
  logic [QW-1:0]   head, head_next;
  logic [QW-1:0]   tail, tail_next;
  logic [7:0]      firmware_version;

  // Job ring and configuration store
  job_t            job_queue [QUEUE_SLOTS];
  logic [7:0]      store [CONFIG_BYTES];
  logic            store_valid [CONFIG_BYTES];

  // Step controls
  logic            accept;
  logic            push_en;
  source_t         push_src;
  logic [7:0]      push_last;
  logic            count_en;
  logic            store_we;
  logic [AW-1:0]   store_waddr;
  logic [AW-1:0]   store_raddr;
  job_t            tail_job;
  logic            res_valid;
  event_t          res_kind;
  source_t         res_src;
  logic [7:0]      res_index;
  logic [7:0]      res_value;
  logic            res_from_store;
  logic [3:0]      res_ticks;
  logic            res_dropped;

  // Output register
  event_t          ev_q;
  source_t         src_q;
  logic [7:0]      index_q;
  logic [7:0]      value_q;
  logic            from_store_q;
  logic [3:0]      ticks_q;
  logic            pending_q;
  logic            dropped_q;
  logic [7:0]      rd_data;
  logic            rd_valid;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign tail_job = job_queue[tail];
  assign store_raddr = tail_job.count[AW-1:0];
  assign store_waddr = pending_offset[AW-1:0];

  // Step the parser and the job ring
  always_comb begin
    logic [QW-1:0] head_inc;
    logic [QW-1:0] tail_inc;
    head_inc = (head == PTR_LAST) ? '0 : head + 1'b1;
    tail_inc = (tail == PTR_LAST) ? '0 : tail + 1'b1;

    phase_next     = phase;
    offset_next    = pending_offset;
    head_next      = head;
    tail_next      = tail;
    push_en        = 1'b0;
    push_src       = SRC_STORE;
    push_last      = LAST_SINGLE;
    count_en       = 1'b0;
    store_we       = 1'b0;
    res_valid      = 1'b0;
    res_kind       = EV_TX_BYTE;
    res_src        = SRC_STORE;
    res_index      = '0;
    res_value      = '0;
    res_from_store = 1'b0;
    res_ticks      = '0;
    res_dropped    = 1'b0;

    if (mode) begin
      // Send the next byte of the oldest job
      if (head != tail) begin
        res_valid = 1'b1;
        res_src   = tail_job.source;
        res_index = tail_job.count;
        if (tail_job.source == SRC_STORE) begin
          res_from_store = ({1'b0, tail_job.count} < STORE_SIZE);
        end else if (tail_job.source == SRC_VERSION) begin
          res_value = firmware_version;
        end
        if (tail_job.count < tail_job.last) begin
          count_en = 1'b1;
        end else begin
          tail_next = tail_inc;
        end
      end
    end else begin
      case (phase)
        PH_OFFSET: begin
          offset_next = rx_byte;
          phase_next  = PH_VALUE;
        end
        PH_VALUE: begin
          phase_next = PH_CMD;
          if ({1'b0, pending_offset} < STORE_SIZE) begin
            store_we  = 1'b1;
            res_valid = 1'b1;
            res_kind  = EV_CONFIG_WRITE;
            res_index = pending_offset;
            res_value = rx_byte;
          end
        end
        default: begin
          phase_next = PH_CMD;
          case (rx_byte)
            CMD_REALTIME: begin
              push_en   = 1'b1;
              push_src  = SRC_REALTIME;
              push_last = LAST_REALTIME;
            end
            CMD_SECONDS: begin
              push_en  = 1'b1;
              push_src = SRC_SECONDS;
            end
            CMD_VERSION: begin
              push_en  = 1'b1;
              push_src = SRC_VERSION;
            end
            CMD_STORE: begin
              push_en   = 1'b1;
              push_last = LAST_STORE;
            end
            CMD_SHORT: begin
              push_en   = 1'b1;
              push_last = LAST_SHORT;
            end
            CMD_SAVE: begin
              res_valid = 1'b1;
              res_kind  = EV_SAVE;
            end
            CMD_OPEN: begin
              res_valid = 1'b1;
              res_kind  = EV_STEP_OPEN;
              res_ticks = STEP_TICK_COUNT;
            end
            CMD_CLOSE: begin
              res_valid = 1'b1;
              res_kind  = EV_STEP_CLOSE;
              res_ticks = STEP_TICK_COUNT;
            end
            CMD_FLUSH: begin
              head_next = '0;
              tail_next = '0;
            end
            CMD_WRITE: begin
              phase_next = PH_OFFSET;
            end
            default: begin
            end
          endcase
          // Drop the job when the ring is full
          if (push_en && head_inc == tail) begin
            push_en     = 1'b0;
            res_valid   = 1'b1;
            res_dropped = 1'b1;
          end else if (push_en) begin
            head_next = head_inc;
          end
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_CMD;
      pending_offset <= '0;
      head           <= '0;
      tail           <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      pending_offset <= offset_next;
      head           <= head_next;
      tail           <= tail_next;
    end
  end

  // Job ring entries
  always_ff @(posedge clk) begin
    if (accept && push_en) begin
      job_queue[head] <= '{source: push_src, last: push_last, count: 8'd0};
    end else if (accept && count_en) begin
      job_queue[tail].count <= tail_job.count + 8'd1;
    end
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (accept && store_we) begin
      store[store_waddr] <= rx_byte;
    end
    if (accept) begin
      rd_data <= store[store_raddr];
    end
  end

  // Store valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CONFIG_BYTES; i++) begin
        store_valid[i] <= 1'b0;
      end
      rd_valid <= 1'b0;
    end else if (accept) begin
      if (store_we) begin
        store_valid[store_waddr] <= 1'b1;
      end
      rd_valid <= store_valid[store_raddr];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ev_q         <= res_kind;
      src_q        <= res_src;
      index_q      <= res_index;
      value_q      <= res_value;
      from_store_q <= res_from_store;
      ticks_q      <= res_ticks;
      pending_q    <= (head_next != tail_next);
      dropped_q    <= res_dropped;
    end
  end

  assign event_kind  = ev_q;
  assign tx_source   = src_q;
  assign byte_index  = index_q;
  assign byte_value  = from_store_q ? (rd_valid ? rd_data : 8'd0) : value_q;
  assign step_ticks  = ticks_q;
  assign tx_pending  = pending_q;
  assign job_dropped = dropped_q;

  // Configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      firmware_version <= '0;
    end else if (psel && penable && pwrite && pready
                 && paddr[1] == REG_FIRMWARE_VERSION) begin
      firmware_version <= pwdata[7:0];
    end
  end

  // Read back the version register where paddr[1] is clear; other addresses read zero
  assign prdata = (paddr[1] == REG_FIRMWARE_VERSION) ? {24'd0, firmware_version} : 32'd0;

  assign pready = 1'b1;

  // Held result reflects the ring as the last transaction left it
  a_pending_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tx_pending == (head != tail)))
    else $error("tx_pending disagrees with ring pointers");

  // A dropped job implies a full, hence nonempty, ring
  a_drop_pending: assert property (@(posedge clk) disable iff (rst)
    (out_valid && job_dropped) |-> (tx_pending && event_kind == EV_TX_BYTE))
    else $error("dropped job without a pending queue");

  // Stepper events carry the tick count
  a_step_ticks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_kind == EV_STEP_OPEN || event_kind == EV_STEP_CLOSE))
      |-> (step_ticks == STEP_TICK_COUNT))
    else $error("stepper event without tick count");

  // Flush empties the ring
  a_flush: assert property (@(posedge clk) disable iff (rst)
    (accept && !mode && phase != PH_OFFSET && phase != PH_VALUE && rx_byte == CMD_FLUSH)
      |=> (head == '0 && tail == '0))
    else $error("flush did not clear the ring");

endmodule

/* dv/tb_serial_command_response_engine.sv */
`timescale 1ns / 1ps

module tb_serial_command_response_engine;
  import scre_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam logic [1:0] VERSION_ADDR = 2'(4 * REG_FIRMWARE_VERSION);
  localparam logic MODE_BYTE  = 1'b0;
  localparam logic MODE_READY = 1'b1;

  typedef struct {
    event_t     kind;
    source_t    source;
    logic [7:0] index;
    logic [7:0] value;
    logic [3:0] ticks;
    logic       pending;
    logic       dropped;
  } response_t;

  // Mirror of the command parser, config store and response job ring
  class engine_scoreboard;
    logic [7:0]  version;
    phase_t      phase;
    logic [7:0]  write_offset;
    logic [7:0]  store [CONFIG_BYTES_DEF];
    job_t        jobs [QUEUE_SLOTS_DEF];
    int unsigned head;
    int unsigned tail;
    response_t   expected_responses [$];
    int          errors;

    function new();
      version      = 8'h00;
      phase        = PH_CMD;
      write_offset = 8'h00;
      head         = 0;
      tail         = 0;
      errors       = 0;
      foreach (store[i]) store[i] = 8'h00;
      foreach (jobs[i]) jobs[i] = '0;
    endfunction

    function void set_version(logic [7:0] v);
      version = v;
    endfunction

    function void add_response(event_t kind, source_t src, logic [7:0] index,
                               logic [7:0] value, logic [3:0] ticks, logic dropped);
      response_t r;
      r.kind    = kind;
      r.source  = src;
      r.index   = index;
      r.value   = value;
      r.ticks   = ticks;
      r.pending = (head != tail);
      r.dropped = dropped;
      expected_responses.push_back(r);
    endfunction

    // Queue a job unless the ring is full; one slot always stays free
    function bit queue_job(source_t src, int len);
      int unsigned nxt;
      nxt = (head + 1) % QUEUE_SLOTS_DEF;
      if (nxt == tail) return 1'b0;
      jobs[head].source = src;
      jobs[head].last   = 8'((len > 0) ? len - 1 : 0);
      jobs[head].count  = 8'h00;
      head = nxt;
      return 1'b1;
    endfunction

    // Work out the response, if any, of one accepted input transaction
    function void note_transaction(logic m, logic [7:0] rx);
      source_t    src;
      logic [7:0] idx;
      logic [7:0] val;
      bit         queued;
      if (m == MODE_READY) begin
        if (head == tail) return;
        src = jobs[tail].source;
        idx = jobs[tail].count;
        val = 8'h00;
        if (src == SRC_STORE)
          val = (int'(idx) < CONFIG_BYTES_DEF) ? store[idx] : 8'h00;
        else if (src == SRC_VERSION)
          val = version;
        if (jobs[tail].count < jobs[tail].last)
          jobs[tail].count = jobs[tail].count + 8'd1;
        else
          tail = (tail + 1) % QUEUE_SLOTS_DEF;
        add_response(EV_TX_BYTE, src, idx, val, 4'd0, 1'b0);
        return;
      end
      case (phase)
        PH_OFFSET: begin
          write_offset = rx;
          phase = PH_VALUE;
          return;
        end
        PH_VALUE: begin
          phase = PH_CMD;
          if (int'(write_offset) < CONFIG_BYTES_DEF) begin
            store[write_offset] = rx;
            add_response(EV_CONFIG_WRITE, SRC_STORE, write_offset, rx, 4'd0, 1'b0);
          end
          return;
        end
        default: phase = PH_CMD;
      endcase
      case (rx)
        CMD_REALTIME: queued = queue_job(SRC_REALTIME, REALTIME_LEN);
        CMD_SECONDS:  queued = queue_job(SRC_SECONDS, 1);
        CMD_VERSION:  queued = queue_job(SRC_VERSION, 1);
        CMD_STORE:    queued = queue_job(SRC_STORE, CONFIG_BYTES_DEF);
        CMD_SHORT:    queued = queue_job(SRC_STORE, SHORT_STORE_LEN);
        CMD_SAVE: begin
          add_response(EV_SAVE, SRC_STORE, 8'h00, 8'h00, 4'd0, 1'b0);
          return;
        end
        CMD_OPEN: begin
          add_response(EV_STEP_OPEN, SRC_STORE, 8'h00, 8'h00, STEP_TICK_COUNT, 1'b0);
          return;
        end
        CMD_CLOSE: begin
          add_response(EV_STEP_CLOSE, SRC_STORE, 8'h00, 8'h00, STEP_TICK_COUNT, 1'b0);
          return;
        end
        CMD_FLUSH: begin
          head = 0;
          tail = 0;
          return;
        end
        CMD_WRITE: begin
          phase = PH_OFFSET;
          return;
        end
        default: return;
      endcase
      if (!queued)
        add_response(EV_TX_BYTE, SRC_STORE, 8'h00, 8'h00, 4'd0, 1'b1);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    // Compare one accepted response against the oldest expectation
    task check_response(response_t got);
      response_t want;
      if (expected_responses.size() == 0) begin
        report_mismatch("unexpected response kind", got.kind, -1);
        return;
      end
      want = expected_responses.pop_front();
      if (got.kind !== want.kind)       report_mismatch("event_kind", got.kind, want.kind);
      if (got.source !== want.source)   report_mismatch("tx_source", got.source, want.source);
      if (got.index !== want.index)     report_mismatch("byte_index", got.index, want.index);
      if (got.value !== want.value)     report_mismatch("byte_value", got.value, want.value);
      if (got.ticks !== want.ticks)     report_mismatch("step_ticks", got.ticks, want.ticks);
      if (got.pending !== want.pending) report_mismatch("tx_pending", got.pending, want.pending);
      if (got.dropped !== want.dropped) report_mismatch("job_dropped", got.dropped, want.dropped);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode = 1'b0;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  event_kind;
  logic [1:0]  tx_source;
  logic [7:0]  byte_index;
  logic [7:0]  byte_value;
  logic [3:0]  step_ticks;
  logic        tx_pending;
  logic        job_dropped;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = 2'b00;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  engine_scoreboard sb = new();
  int in_taken = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  serial_command_response_engine u_dut (
    .clk, .rst,
    .in_valid, .in_stall, .mode, .rx_byte,
    .out_valid, .out_stall, .event_kind, .tx_source, .byte_index, .byte_value,
    .step_ticks, .tx_pending, .job_dropped,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // End the run if the engine hangs
  initial begin
    #(2_000_000);
    $display("tb_serial_command_response_engine: done, errors");
    $finish;
  end

  // Sample both channels at the rising edge; check older responses first
  always @(posedge clk) begin
    response_t got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got.kind    = event_t'(event_kind);
        got.source  = source_t'(tx_source);
        got.index   = byte_index;
        got.value   = byte_value;
        got.ticks   = step_ticks;
        got.pending = tx_pending;
        got.dropped = job_dropped;
        sb.check_response(got);
      end
      if (in_valid && !in_stall) begin
        sb.note_transaction(mode, rx_byte);
        in_taken++;
      end
    end
  end

  // Random receiver backpressure
  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Present one transaction and hold it until accepted
  task automatic send_item(input logic m, input logic [7:0] b);
    int seen;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    rx_byte  <= b;
    seen = in_taken;
    do @(negedge clk); while (in_taken == seen);
  endtask

  task automatic send_ready(input int n);
    repeat (n) send_item(MODE_READY, 8'($urandom));
  endtask

  task automatic send_write(input logic [7:0] offset, input logic [7:0] value);
    send_item(MODE_BYTE, CMD_WRITE);
    send_item(MODE_BYTE, offset);
    send_item(MODE_BYTE, value);
  endtask

  // Drop valid and wait until every response is back plus the pipeline depth
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_responses.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Setup phase then access phase on the config port
  task automatic write_version(input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= VERSION_ADDR;
    pwdata  <= {24'h0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_version(v);
  endtask

  task automatic run_directed();
    send_item(MODE_READY, 8'hFF);
    send_write(8'h00, 8'hFF);
    send_write(8'h7F, 8'h00);
    send_write(8'h80, 8'h12);
    send_item(MODE_BYTE, CMD_SAVE);
    send_item(MODE_BYTE, CMD_OPEN);
    send_item(MODE_BYTE, CMD_CLOSE);
    send_item(MODE_BYTE, CMD_VERSION);
    send_ready(1);
    // fill the ring, then overflow it
    send_item(MODE_BYTE, CMD_REALTIME);
    send_item(MODE_BYTE, CMD_SECONDS);
    send_item(MODE_BYTE, CMD_SHORT);
    send_item(MODE_BYTE, CMD_STORE);
    send_item(MODE_BYTE, CMD_FLUSH);
    send_item(MODE_BYTE, CMD_SECONDS);
    send_ready(2);
    send_item(MODE_BYTE, 8'h00);
  endtask

  // Mostly well-formed command sequences with random content
  task automatic run_random(input int target);
    logic [7:0] queries [5] = '{CMD_REALTIME, CMD_SECONDS, CMD_VERSION, CMD_STORE, CMD_SHORT};
    logic [7:0] controls [3] = '{CMD_SAVE, CMD_OPEN, CMD_CLOSE};
    logic [7:0] offset;
    int sent;
    int r;
    int n;
    sent = 0;
    while (sent < target) begin
      r = $urandom_range(99);
      if (r < 25) begin
        offset = ($urandom_range(99) < 85) ? 8'($urandom_range(127)) : 8'($urandom_range(128, 255));
        send_write(offset, 8'($urandom));
        sent += 3;
      end else if (r < 55) begin
        send_item(MODE_BYTE, queries[$urandom_range(4)]);
        n = ($urandom_range(99) < 10) ? 130 : $urandom_range(25);
        send_ready(n);
        sent += 1 + n;
      end else if (r < 65) begin
        send_item(MODE_BYTE, controls[$urandom_range(2)]);
        sent += 1;
      end else if (r < 70) begin
        send_item(MODE_BYTE, CMD_FLUSH);
        sent += 1;
      end else if (r < 80) begin
        n = $urandom_range(1, 8);
        send_ready(n);
        sent += n;
      end else if (r < 88) begin
        // write broken up by ready ticks in the middle
        n = $urandom_range(1, 3);
        send_item(MODE_BYTE, CMD_WRITE);
        send_ready(n);
        send_item(MODE_BYTE, 8'($urandom));
        send_ready(1);
        send_item(MODE_BYTE, 8'($urandom));
        sent += 4 + n;
      end else begin
        send_item(1'($urandom), 8'($urandom));
        sent += 1;
      end
    end
  endtask

  initial begin
    int idles [4]  = '{0, 46, 0, 24};
    int stalls [4] = '{0, 0, 46, 24};
    logic [7:0] versions [4];
    int waited;
    versions = '{8'hFF, 8'h00, 8'($urandom), 8'h01};
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_version(8'h5A);
    run_directed();
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      write_version(versions[p]);
      idle_pct  = idles[p];
      stall_pct = stalls[p];
      run_random(440);
    end
    in_valid <= 1'b0;
    waited = 0;
    while (sb.expected_responses.size() != 0 && waited < 10000) begin
      @(negedge clk);
      waited++;
    end
    repeat (10) @(negedge clk);
    if (sb.expected_responses.size() != 0) begin
      sb.report_mismatch("outstanding responses", 0, sb.expected_responses.size());
    end
    if (sb.errors == 0) begin
      $display("tb_serial_command_response_engine: done, clean");
    end else begin
      $display("tb_serial_command_response_engine: done, errors");
    end
    $finish;
  end

endmodule
